// ===== rtl/core/dsp_pkg.sv =====
// shared types, codes and constants for the duration string parser
// used by dsp_char_class, dsp_accum and duration_string_parser; no dependencies

package dsp_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MALFORMED = 3'd1,
    ST_NEGATIVE  = 3'd2,
    ST_BADUNIT   = 3'd3,
    ST_TOOBIG    = 3'd4
  } status_t;

  // latched error codes, same values as the matching status codes
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_NEGATIVE  = 2'd2,
    ERR_BADUNIT   = 2'd3
  } err_t;

  localparam int VAL_W  = 31;
  localparam int MULT_W = 20;
  localparam int PROD_W = VAL_W + MULT_W;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  localparam logic [MULT_W-1:0] SEC_WEEK   = MULT_W'(7 * 24 * 60 * 60);
  localparam logic [MULT_W-1:0] SEC_DAY    = MULT_W'(24 * 60 * 60);
  localparam logic [MULT_W-1:0] SEC_HOUR   = MULT_W'(60 * 60);
  localparam logic [MULT_W-1:0] SEC_MINUTE = MULT_W'(60);
  localparam logic [MULT_W-1:0] SEC_SECOND = MULT_W'(1);

  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // character classification
  typedef struct packed {
    logic              is_num;
    logic [3:0]        digit;
    logic              is_unit;
    logic [MULT_W-1:0] mult;
    logic              is_minus;
  } char_class_t;

  // one result
  typedef struct packed {
    logic [VAL_W-1:0] secs;
    status_t          status;
  } result_t;

endpackage

// ===== rtl/core/duration_string_parser.sv =====
// top level of the duration string parser: input register, decoder, accumulator, output register
// depends on dsp_pkg, dsp_char_class and dsp_accum

// Takes a duration text such as "1w2d3h4m5s" one ASCII character per input beat,
// with in_tlast on the final character, and returns one beat per string holding a
// status (ok, malformed, negative, invalid unit, too big) and the duration in
// seconds (zero unless ok). Digits left at the end count as seconds; the first
// error wins and the rest of the string is ignored; sums past 2^31-1 give too big.
// Throughput is one character per clock while nothing stalls: each character
// goes through a single multiply-add of the digit run against the unit's seconds
// constant and the running total, computed combinationally. The last character is
// registered in the input register and its result then in the output register,
// which drives out_tvalid; a full output register can hold it in between.
// The input side keeps accepting while a finished result waits on out_tready;
// only a last character stalls when the output register is still full.

module duration_string_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,   // last_char
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [2:0] status, [33:3] total_seconds, [39:34] zero
);

  localparam int VW = dsp_pkg::VAL_W;

  // input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;

  // output register
  logic              out_v_r, out_v_nxt;
  dsp_pkg::result_t  res_r, res_nxt;

  dsp_pkg::char_class_t cls;
  dsp_pkg::result_t     result;
  logic                 fire;
  logic                 load_out;

  // a held character is processed unless it is a last one facing a full output that out_tready is not draining
  assign fire      = in_v_r && (!last_r || !out_v_r || out_tready);
  assign load_out  = fire && last_r;
  assign in_tready = !in_v_r || fire;

  dsp_char_class u_class (
    .character (char_r),
    .cls       (cls)
  );

  dsp_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .last   (last_r),
    .cls    (cls),
    .result (result)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    char_nxt = char_r;
    last_nxt = last_r;
    if (in_tready) begin
      in_v_nxt = in_tvalid;
      char_nxt = in_tdata;
      last_nxt = in_tlast;
    end

    out_v_nxt = out_v_r;
    res_nxt   = res_r;
    if (load_out) begin
      out_v_nxt = 1'b1;
      res_nxt   = result;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
    res_r  <= res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, res_r.secs[VW-1:0], res_r.status};

endmodule

// ===== rtl/core/dsp_char_class.sv =====
// character decoder: digit, unit letter with its seconds multiplier, minus sign
// depends on dsp_pkg

module dsp_char_class (
  input  logic [7:0]           character,
  output dsp_pkg::char_class_t cls
);

  always_comb begin
    cls          = '0;
    cls.is_num   = (character >= dsp_pkg::CH_ZERO) && (character <= dsp_pkg::CH_NINE);
    cls.digit    = character[3:0];
    unique case (character)
      dsp_pkg::CH_W: begin
        cls.is_unit = 1'b1;
        cls.mult    = dsp_pkg::SEC_WEEK;
      end
      dsp_pkg::CH_D: begin
        cls.is_unit = 1'b1;
        cls.mult    = dsp_pkg::SEC_DAY;
      end
      dsp_pkg::CH_H: begin
        cls.is_unit = 1'b1;
        cls.mult    = dsp_pkg::SEC_HOUR;
      end
      dsp_pkg::CH_M: begin
        cls.is_unit = 1'b1;
        cls.mult    = dsp_pkg::SEC_MINUTE;
      end
      dsp_pkg::CH_S: begin
        cls.is_unit = 1'b1;
        cls.mult    = dsp_pkg::SEC_SECOND;
      end
      dsp_pkg::CH_MINUS: begin
        cls.is_minus = 1'b1;
      end
      default: begin
        cls.is_unit = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/dsp_accum.sv =====
// parse state and per-character arithmetic: digit run, unit multiply-add, error latch
// depends on dsp_pkg

module dsp_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 last,
  input  dsp_pkg::char_class_t cls,
  output dsp_pkg::result_t     result
);

  localparam int VW = dsp_pkg::VAL_W;
  localparam int PW = dsp_pkg::PROD_W;

  logic [VW-1:0]   run_r, run_nxt;
  logic            started_r, started_nxt;
  logic [VW-1:0]   total_r, total_nxt;
  logic            ovf_r, ovf_nxt;
  dsp_pkg::err_t   err_r, err_nxt;
  logic            err_seen_r, err_seen_nxt;

  logic [VW+3:0]   digit_val;
  logic [PW-1:0]   unit_term;
  logic [PW-1:0]   addend;
  logic [PW:0]     sum;
  logic            do_digit, do_unit, do_trail;
  logic [VW-1:0]   s_run;
  logic            s_started, s_ovf, s_err_seen;
  dsp_pkg::err_t   s_err;
  logic [VW-1:0]   s_total;
  logic            f_ovf;

  // run * 10 + digit as shift-add
  assign digit_val = ((VW+4)'(run_r) << 3) + ((VW+4)'(run_r) << 1) + (VW+4)'(cls.digit);
  assign unit_term = PW'(run_r) * PW'(cls.mult);

  always_comb begin
    do_digit   = !err_seen_r && cls.is_num;
    do_unit    = !err_seen_r && !cls.is_num && started_r && cls.is_unit;
    s_run      = run_r;
    s_started  = started_r;
    s_ovf      = ovf_r;
    s_err      = err_r;
    s_err_seen = err_seen_r;
    if (do_digit) begin
      s_started = 1'b1;
      if (digit_val > (VW+4)'(dsp_pkg::VAL_MAX)) begin
        s_ovf = 1'b1;
        s_run = dsp_pkg::VAL_MAX;
      end else begin
        s_run = digit_val[VW-1:0];
      end
    end else if (!err_seen_r) begin
      if (!started_r) begin
        s_err      = dsp_pkg::ERR_MALFORMED;
        s_err_seen = 1'b1;
      end else if (cls.is_unit) begin
        s_run     = '0;
        s_started = 1'b0;
      end else if (cls.is_minus) begin
        s_err      = dsp_pkg::ERR_NEGATIVE;
        s_err_seen = 1'b1;
      end else begin
        s_err      = dsp_pkg::ERR_BADUNIT;
        s_err_seen = 1'b1;
      end
    end

    // one adder serves both the unit term and trailing seconds
    do_trail = last && !s_err_seen && s_started;
    addend   = do_unit ? unit_term : PW'(s_run);
    sum      = (PW+1)'(total_r) + (PW+1)'(addend);
    s_total  = total_r;
    f_ovf    = s_ovf;
    if (do_unit || do_trail) begin
      if (sum > (PW+1)'(dsp_pkg::VAL_MAX)) begin
        f_ovf   = 1'b1;
        s_total = dsp_pkg::VAL_MAX;
      end else begin
        s_total = sum[VW-1:0];
      end
    end

    result.secs = '0;
    if (s_err_seen) begin
      result.status = dsp_pkg::status_t'({1'b0, s_err});
    end else if (f_ovf) begin
      result.status = dsp_pkg::ST_TOOBIG;
    end else begin
      result.status = dsp_pkg::ST_OK;
      result.secs   = s_total;
    end

    run_nxt      = run_r;
    started_nxt  = started_r;
    total_nxt    = total_r;
    ovf_nxt      = ovf_r;
    err_nxt      = err_r;
    err_seen_nxt = err_seen_r;
    if (fire) begin
      if (last) begin
        // end of string: back to the start state
        run_nxt      = '0;
        started_nxt  = 1'b0;
        total_nxt    = '0;
        ovf_nxt      = 1'b0;
        err_nxt      = dsp_pkg::ERR_NONE;
        err_seen_nxt = 1'b0;
      end else begin
        run_nxt      = s_run;
        started_nxt  = s_started;
        total_nxt    = s_total;
        ovf_nxt      = f_ovf;
        err_nxt      = s_err;
        err_seen_nxt = s_err_seen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= '0;
      started_r  <= 1'b0;
      total_r    <= '0;
      ovf_r      <= 1'b0;
      err_r      <= dsp_pkg::ERR_NONE;
      err_seen_r <= 1'b0;
    end else begin
      run_r      <= run_nxt;
      started_r  <= started_nxt;
      total_r    <= total_nxt;
      ovf_r      <= ovf_nxt;
      err_r      <= err_nxt;
      err_seen_r <= err_seen_nxt;
    end
  end

endmodule
